// File: hdl/rch_pkg.sv
// ----------------------------------------------------------------------------
// rch_pkg
// Shared types, codes and helper functions of the region color histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package rch_pkg;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] REG_BINS_FIRST  = 2'd0;
    localparam logic [1:0] REG_BINS_SECOND = 2'd1;
    localparam logic [1:0] REG_BINS_THIRD  = 2'd2;

    localparam logic [1:0] CHAN_FIRST  = 2'd0;
    localparam logic [1:0] CHAN_SECOND = 2'd1;
    localparam logic [1:0] CHAN_THIRD  = 2'd2;

    localparam logic [4:0] BINS_RESET = 5'd8;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_PIX,
        ST_RD_BIN,
        ST_DIV_GO,
        ST_DIV,
        ST_WIPE
    } back_state_t;

    typedef struct packed {
        logic       cmd;
        logic       hit;
        logic [7:0] rid;
        logic [5:0] bin_a;
        logic [5:0] bin_b;
        logic [5:0] bin_c;
        logic [4:0] nb_a;
        logic [4:0] nb_b;
        logic [4:0] nb_c;
    } item_t;

    function automatic logic [4:0] eff_bins(input logic [4:0] r, input logic [4:0] cap);
        logic [4:0] res;
        if (r == 5'd0) res = 5'd1;
        else if (r > cap) res = cap;
        else res = r;
        return res;
    endfunction

    function automatic logic [5:0] chan_bin(input logic [7:0] v, input logic [4:0] nb);
        logic [12:0] prod;
        prod = 13'(v) * 13'(nb);
        return {2'b00, prod[11:8]};
    endfunction

endpackage

`default_nettype wire

// File: hdl/rch_front.sv
// ----------------------------------------------------------------------------
// rch_front
// Accepts input words, holds the bin registers and classifies each word.
// ----------------------------------------------------------------------------
`default_nettype none

module rch_front import rch_pkg::*; #(
    parameter int MAX_BINS    = 16,
    parameter int NUM_REGIONS = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [7:0] s_region_id,
    input  wire logic [7:0] s_chan_a,
    input  wire logic [7:0] s_chan_b,
    input  wire logic [7:0] s_chan_c,
    input  wire logic       q_full,
    input  wire logic       clearing,
    output logic            push,
    output item_t           item
);

    localparam int         CAP    = (MAX_BINS < 16) ? MAX_BINS : 16;
    localparam logic [4:0] CAP_V  = 5'(CAP);
    localparam logic [12:0] NR_V  = 13'(NUM_REGIONS);

    logic [4:0] bins_a_reg, bins_b_reg, bins_c_reg;
    logic [4:0] nb_a, nb_b, nb_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_a_reg <= BINS_RESET;
            bins_b_reg <= BINS_RESET;
            bins_c_reg <= BINS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BINS_FIRST:  bins_a_reg <= cfg_wdata;
                REG_BINS_SECOND: bins_b_reg <= cfg_wdata;
                REG_BINS_THIRD:  bins_c_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign nb_a    = eff_bins(bins_a_reg, CAP_V);
    assign nb_b    = eff_bins(bins_b_reg, CAP_V);
    assign nb_c    = eff_bins(bins_c_reg, CAP_V);
    assign s_ready = !q_full && !clearing;
    assign push    = s_valid && s_ready;

    always_comb begin
        item.cmd   = s_command;
        item.hit   = {5'd0, s_region_id} < NR_V;
        item.rid   = s_region_id;
        item.bin_a = chan_bin(s_chan_a, nb_a);
        item.bin_b = chan_bin(s_chan_b, nb_b);
        item.bin_c = chan_bin(s_chan_c, nb_c);
        item.nb_a  = nb_a;
        item.nb_b  = nb_b;
        item.nb_c  = nb_c;
    end

endmodule

`default_nettype wire

// File: hdl/rch_fifo.sv
// ----------------------------------------------------------------------------
// rch_fifo
// Two-entry queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rch_fifo import rch_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t item_in,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output item_t      item_out
);

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign item_out = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= item_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

// File: hdl/rch_div.sv
// ----------------------------------------------------------------------------
// rch_div
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rch_div #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [COUNT_BITS+7:0]   num,
    input  wire logic [COUNT_BITS+1:0]   den,
    output logic                         busy,
    output logic [7:0]                   quo
);

    localparam int NW = COUNT_BITS + 8;
    localparam int TW = COUNT_BITS + 2;
    localparam int DW = COUNT_BITS + 10;

    logic [NW-1:0] rem_reg;
    logic [TW-1:0] den_reg;
    logic [2:0]    k_reg;
    logic [7:0]    quo_reg;
    logic          busy_reg;
    logic [DW-1:0] trial, rem_ext, diff;
    logic          ge;

    assign trial   = DW'(den_reg) << k_reg;
    assign rem_ext = DW'(rem_reg);
    assign ge      = rem_ext >= trial;
    assign diff    = rem_ext - trial;
    assign busy    = busy_reg;
    assign quo     = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
            k_reg   <= 3'd7;
            quo_reg <= 8'd0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg        <= NW'(diff);
                quo_reg[k_reg] <= 1'b1;
            end
            k_reg <= k_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && k_reg == 3'd0) begin
            busy_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rch_back.sv
// ----------------------------------------------------------------------------
// rch_back
// Executes queued words: counter updates, bin readout and region wipe.
// ----------------------------------------------------------------------------
`default_nettype none

module rch_back import rch_pkg::*; #(
    parameter int MAX_BINS    = 16,
    parameter int NUM_REGIONS = 256,
    parameter int COUNT_BITS  = 24
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_empty,
    input  wire item_t      q_item,
    output logic            q_pop,
    output logic            clearing,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_region,
    output logic [5:0]      m_bin_index,
    output logic [7:0]      m_bin_value,
    output logic            m_last
);

    localparam int RW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int BW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int DEPTH = NUM_REGIONS * MAX_BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = COUNT_BITS;
    localparam int TW    = COUNT_BITS + 2;
    localparam int NW    = COUNT_BITS + 8;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [BW-1:0] LAST_BIN  = BW'(MAX_BINS - 1);
    localparam logic [CW-1:0] CNT_MAX   = {CW{1'b1}};

    logic [CW-1:0] mem_a [DEPTH];
    logic [CW-1:0] mem_b [DEPTH];
    logic [CW-1:0] mem_c [DEPTH];
    logic [CW-1:0] pix_mem [NUM_REGIONS];

    back_state_t   state_reg, state_next;
    item_t         cur_reg, cur_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [BW-1:0] wipe_reg, wipe_next;
    logic [1:0]    chan_reg, chan_next;
    logic [5:0]    idx_reg, idx_next;
    logic [5:0]    n_reg, n_next;
    logic [TW-1:0] total_reg, total_next;
    logic [CW-1:0] rd_a_reg, rd_b_reg, rd_c_reg, pix_rd_reg;

    logic          m_valid_reg, m_last_reg;
    logic [7:0]    m_region_reg, m_value_reg;
    logic [5:0]    m_index_reg;

    logic [RW-1:0] rid_a;
    logic [AW-1:0] base;
    logic [5:0]    bsel_a, bsel_b, bsel_c;
    logic [AW-1:0] addr_a, addr_b, addr_c;
    logic [RW-1:0] pix_addr;
    logic          we, pix_we;
    logic          div_start, div_busy, load_out, out_free, is_last, chan_end;
    logic [7:0]    quo;
    logic [4:0]    nb_cur;
    logic [CW-1:0] cnt_sel;
    logic [NW-1:0] num;

    assign rid_a    = RW'(cur_reg.rid);
    assign base     = AW'(rid_a) * AW'(MAX_BINS);
    assign clearing = state_reg == ST_CLEAR;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (chan_reg)
            CHAN_FIRST:  begin nb_cur = cur_reg.nb_a; cnt_sel = rd_a_reg; end
            CHAN_SECOND: begin nb_cur = cur_reg.nb_b; cnt_sel = rd_b_reg; end
            default:     begin nb_cur = cur_reg.nb_c; cnt_sel = rd_c_reg; end
        endcase
    end

    assign chan_end = (idx_reg + 6'd1) == {1'b0, nb_cur};
    assign is_last  = chan_end && chan_reg == CHAN_THIRD;
    assign num      = {cnt_sel, 8'd0} - NW'(cnt_sel);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (sweep_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE: begin
                if (!q_empty) begin
                    if (q_item.cmd == CMD_READ) state_next = ST_RD_PIX;
                    else if (q_item.hit) state_next = ST_ACC_RD;
                end
            end
            ST_ACC_RD: state_next = ST_ACC_WR;
            ST_ACC_WR: state_next = ST_IDLE;
            ST_RD_PIX: state_next = ST_RD_BIN;
            ST_RD_BIN: state_next = ST_DIV_GO;
            ST_DIV_GO: state_next = ST_DIV;
            ST_DIV: begin
                if (!div_busy && out_free) begin
                    if (!is_last) state_next = ST_RD_BIN;
                    else if (cur_reg.hit) state_next = ST_WIPE;
                    else state_next = ST_IDLE;
                end
            end
            ST_WIPE:   if (wipe_reg == LAST_BIN) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        q_pop      = 1'b0;
        we         = 1'b0;
        pix_we     = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        cur_next   = cur_reg;
        sweep_next = sweep_reg;
        wipe_next  = wipe_reg;
        chan_next  = chan_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        total_next = total_reg;
        bsel_a     = idx_reg;
        bsel_b     = idx_reg;
        bsel_c     = idx_reg;
        case (state_reg)
            ST_CLEAR: begin
                we         = 1'b1;
                pix_we     = 1'b1;
                sweep_next = sweep_reg + AW'(1);
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    cur_next  = q_item;
                    chan_next = CHAN_FIRST;
                    idx_next  = 6'd0;
                    n_next    = 6'd0;
                    wipe_next = '0;
                end
            end
            ST_ACC_RD, ST_ACC_WR: begin
                bsel_a = cur_reg.bin_a;
                bsel_b = cur_reg.bin_b;
                bsel_c = cur_reg.bin_c;
                we     = state_reg == ST_ACC_WR;
                pix_we = state_reg == ST_ACC_WR;
            end
            ST_RD_BIN: begin
                total_next = cur_reg.hit ? (TW'(pix_rd_reg) + (TW'(pix_rd_reg) << 1)) : '0;
            end
            ST_DIV_GO: div_start = 1'b1;
            ST_DIV: begin
                if (!div_busy && out_free) begin
                    load_out = 1'b1;
                    n_next   = n_reg + 6'd1;
                    if (chan_end) begin
                        chan_next = chan_reg + 2'd1;
                        idx_next  = 6'd0;
                    end else begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            ST_WIPE: begin
                bsel_a    = 6'(wipe_reg);
                bsel_b    = 6'(wipe_reg);
                bsel_c    = 6'(wipe_reg);
                we        = 1'b1;
                pix_we    = 1'b1;
                wipe_next = wipe_reg + BW'(1);
            end
            default: ;
        endcase
    end

    assign addr_a   = clearing ? sweep_reg : base + AW'(bsel_a[BW-1:0]);
    assign addr_b   = clearing ? sweep_reg : base + AW'(bsel_b[BW-1:0]);
    assign addr_c   = clearing ? sweep_reg : base + AW'(bsel_c[BW-1:0]);
    assign pix_addr = clearing ? sweep_reg[RW-1:0] : rid_a;

    always_ff @(posedge aclk) begin
        rd_a_reg   <= mem_a[addr_a];
        rd_b_reg   <= mem_b[addr_b];
        rd_c_reg   <= mem_c[addr_c];
        pix_rd_reg <= pix_mem[pix_addr];
        if (we) begin
            mem_a[addr_a] <= (state_reg == ST_ACC_WR && rd_a_reg != CNT_MAX) ?
                             rd_a_reg + CW'(1) : (state_reg == ST_ACC_WR ? rd_a_reg : '0);
            mem_b[addr_b] <= (state_reg == ST_ACC_WR && rd_b_reg != CNT_MAX) ?
                             rd_b_reg + CW'(1) : (state_reg == ST_ACC_WR ? rd_b_reg : '0);
            mem_c[addr_c] <= (state_reg == ST_ACC_WR && rd_c_reg != CNT_MAX) ?
                             rd_c_reg + CW'(1) : (state_reg == ST_ACC_WR ? rd_c_reg : '0);
        end
        if (pix_we) begin
            pix_mem[pix_addr] <= (state_reg == ST_ACC_WR && pix_rd_reg != CNT_MAX) ?
                                 pix_rd_reg + CW'(1) :
                                 (state_reg == ST_ACC_WR ? pix_rd_reg : '0);
        end
    end

    rch_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (total_reg),
        .busy    (div_busy),
        .quo     (quo)
    );

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        wipe_reg  <= wipe_next;
        chan_reg  <= chan_next;
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        total_reg <= total_next;
        if (load_out) begin
            m_region_reg <= cur_reg.rid;
            m_index_reg  <= n_reg;
            m_value_reg  <= (total_reg == '0) ? 8'd0 : quo;
            m_last_reg   <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_region = m_region_reg;
    assign m_bin_index  = m_index_reg;
    assign m_bin_value  = m_value_reg;
    assign m_last       = m_last_reg;

endmodule

`default_nettype wire

// File: hdl/region_color_histogram.sv
// ----------------------------------------------------------------------------
// region_color_histogram
// Per-region three-channel color histograms with normalized bin readout.
//
//   channel  ports                          word
//   input    s_valid / s_ready              command, region, three channels
//   result   m_valid / m_ready              one normalized bin per word
//   config   cfg_wr_en, cfg_index, cfg_wdata bin count of a channel
//
// An accumulate word passes the back as a pop, a counter read and a write.
// Each bin of a readout takes a memory read plus the 8-step divider, and an
// in-range region is then wiped bin by bin.
// After reset a clearing pass over every counter address zeroes the
// counters; s_ready stays low meanwhile. A two-word queue lets the input
// side run ahead while the back or the result side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module region_color_histogram import rch_pkg::*; #(
    parameter int MAX_BINS    = 16,
    parameter int NUM_REGIONS = 256,
    parameter int COUNT_BITS  = 24
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [7:0] s_region_id,
    input  wire logic [7:0] s_chan_a,
    input  wire logic [7:0] s_chan_b,
    input  wire logic [7:0] s_chan_c,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_region,
    output logic [5:0]      m_bin_index,
    output logic [7:0]      m_bin_value,
    output logic            m_last
);

    item_t push_item, pop_item;
    logic  push, pop, q_full, q_empty, clearing;

    rch_front #(.MAX_BINS(MAX_BINS), .NUM_REGIONS(NUM_REGIONS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_region_id (s_region_id),
        .s_chan_a    (s_chan_a),
        .s_chan_b    (s_chan_b),
        .s_chan_c    (s_chan_c),
        .q_full      (q_full),
        .clearing    (clearing),
        .push        (push),
        .item        (push_item)
    );

    rch_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .item_in  (push_item),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .item_out (pop_item)
    );

    rch_back #(
        .MAX_BINS    (MAX_BINS),
        .NUM_REGIONS (NUM_REGIONS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_item       (pop_item),
        .q_pop        (pop),
        .clearing     (clearing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_region (m_out_region),
        .m_bin_index  (m_bin_index),
        .m_bin_value  (m_bin_value),
        .m_last       (m_last)
    );

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready) else $error("word accepted during clearing pass");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !m_valid) else $error("result shown during clearing pass");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty) else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the region color histogram. Pixels are binned into
// per-region counters by a local predictor. Every readout word is compared
// with the predicted normalized bin, in order. Directed tests cover channel
// extremes, bin-count extremes and out-of-range register values, empty
// regions, and bin counts changed before a readout. Random phases then run
// with sender gaps and receiver stalls, then a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import rch_pkg::*;;

    localparam int NREG      = 256;
    localparam int SLOTS     = 48;
    localparam int CNT_MAX   = (1 << 24) - 1;
    localparam int WDOG_MAX  = 20000;
    localparam int IDLE_WAIT = 60;

    typedef struct {
        logic [7:0] region;
        logic [5:0] index;
        logic [7:0] value;
        logic       last;
    } bin_word_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [4:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic       s_command;
    logic [7:0] s_region_id;
    logic [7:0] s_chan_a;
    logic [7:0] s_chan_b;
    logic [7:0] s_chan_c;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_region;
    logic [5:0] m_bin_index;
    logic [7:0] m_bin_value;
    logic       m_last;

    region_color_histogram u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_region_id  (s_region_id),
        .s_chan_a     (s_chan_a),
        .s_chan_b     (s_chan_b),
        .s_chan_c     (s_chan_c),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_region (m_out_region),
        .m_bin_index  (m_bin_index),
        .m_bin_value  (m_bin_value),
        .m_last       (m_last)
    );

    int unsigned bin_count [NREG][SLOTS];
    int unsigned pixel_count [NREG];
    logic [4:0]  bins_reg [3];
    bin_word_t   expected_bins [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int mismatches;
    int words_checked;
    int items_sent;
    int readouts_sent;
    int quiet_cycles;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int eff_bins(input logic [4:0] r);
        if (r == 5'd0) return 1;
        if (r > 5'd16) return 16;
        return int'(r);
    endfunction

    function automatic int unsigned sat_inc(input int unsigned x);
        return (x >= CNT_MAX) ? CNT_MAX : x + 1;
    endfunction

    function automatic void predict_histogram(input logic cmd, input logic [7:0] rid,
                                              input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int nb [3];
        logic [7:0] chan [3];
        int slot;
        int n;
        int total_bins;
        longint total;
        bin_word_t w;
        chan[0] = a;
        chan[1] = b;
        chan[2] = c;
        for (int k = 0; k < 3; k++) nb[k] = eff_bins(bins_reg[k]);
        if (cmd == CMD_ACCUM) begin
            for (int k = 0; k < 3; k++) begin
                slot = k * 16 + ((int'(chan[k]) * nb[k]) >> 8);
                bin_count[rid][slot] = sat_inc(bin_count[rid][slot]);
            end
            pixel_count[rid] = sat_inc(pixel_count[rid]);
            return;
        end
        total_bins = nb[0] + nb[1] + nb[2];
        total = 3 * longint'(pixel_count[rid]);
        n = 0;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < nb[k]; i++) begin
                longint v;
                v = 0;
                if (total != 0) v = (longint'(bin_count[rid][k * 16 + i]) * 255) / total;
                if (v > 255) v = 255;
                w.region = rid;
                w.index  = 6'(n);
                w.value  = 8'(v);
                w.last   = (n + 1 == total_bins);
                expected_bins.push_back(w);
                n++;
            end
        end
        for (int s = 0; s < SLOTS; s++) bin_count[rid][s] = 0;
        pixel_count[rid] = 0;
    endfunction

    task automatic send_word(input logic cmd, input logic [7:0] rid, input logic [7:0] a,
                             input logic [7:0] b, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_command   = cmd;
        s_region_id = rid;
        s_chan_a    = a;
        s_chan_b    = b;
        s_chan_c    = c;
        do @(posedge aclk); while (!s_ready);
        predict_histogram(cmd, rid, a, b, c);
        items_sent++;
        if (cmd == CMD_READ) readouts_sent++;
        @(negedge aclk);
    endtask

    task automatic accum(input logic [7:0] rid, input logic [7:0] a, input logic [7:0] b,
                         input logic [7:0] c);
        send_word(CMD_ACCUM, rid, a, b, c);
    endtask

    task automatic readout(input logic [7:0] rid);
        send_word(CMD_READ, rid, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (expected_bins.size() != 0) @(negedge aclk);
        repeat (IDLE_WAIT) @(negedge aclk);
    endtask

    task automatic write_bins(input logic [4:0] fa, input logic [4:0] fb, input logic [4:0] fc);
        logic [4:0] v [3];
        logic [1:0] idx [3];
        v[0] = fa;
        v[1] = fb;
        v[2] = fc;
        idx[0] = REG_BINS_FIRST;
        idx[1] = REG_BINS_SECOND;
        idx[2] = REG_BINS_THIRD;
        wait_idle();
        for (int k = 0; k < 3; k++) begin
            cfg_wr_en = 1'b1;
            cfg_index = idx[k];
            cfg_wdata = v[k];
            @(negedge aclk);
            bins_reg[k] = v[k];
        end
        cfg_wr_en = 1'b0;
    endtask

    task automatic test_default_bins();
        accum(8'd0, 8'd0, 8'd0, 8'd0);
        accum(8'd0, 8'd255, 8'd255, 8'd255);
        accum(8'd0, 8'd128, 8'd31, 8'd32);
        accum(8'd0, 8'd127, 8'd224, 8'd223);
        readout(8'd0);
        readout(8'd5);
        accum(8'd255, 8'hAA, 8'h55, 8'hF0);
        readout(8'd255);
    endtask

    task automatic test_bin_extremes();
        write_bins(5'd1, 5'd16, 5'd16);
        accum(8'd7, 8'd255, 8'd15, 8'd240);
        accum(8'd7, 8'd0, 8'd16, 8'd255);
        readout(8'd7);
        write_bins(5'd0, 5'd17, 5'd31);
        accum(8'd9, 8'd200, 8'd255, 8'd1);
        readout(8'd9);
    endtask

    task automatic test_bins_changed();
        write_bins(5'd8, 5'd8, 5'd8);
        accum(8'd3, 8'd250, 8'd100, 8'd60);
        accum(8'd3, 8'd10, 8'd130, 8'd190);
        accum(8'd3, 8'd250, 8'd100, 8'd60);
        write_bins(5'd3, 5'd16, 5'd2);
        readout(8'd3);
        readout(8'd3);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
        logic [7:0] rid;
        write_bins(5'($urandom_range(31)), 5'($urandom_range(1, 16)),
                   5'($urandom_range(1, 16)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            rid = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            if ($urandom_range(5) == 0) readout(rid);
            else accum(rid, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        for (int r = 0; r < 4; r++) readout(8'(r));
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_bins(5'd16, 5'd16, 5'd16);
        accum(8'd20, 8'd1, 8'd2, 8'd3);
        hold_cycles = 400;
        for (int i = 0; i < 4; i++) readout(8'd20 + 8'(i));
        accum(8'd21, 8'd250, 8'd140, 8'd70);
        readout(8'd21);
        wait_idle();
        accum(8'd22, 8'd90, 8'd90, 8'd90);
        readout(8'd22);
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 1'b0;
            hold_cycles--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bins.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: region %0d index %0d value %0d last %0d",
                             m_out_region, m_bin_index, m_bin_value, m_last);
            end else begin
                bin_word_t e;
                e = expected_bins.pop_front();
                words_checked++;
                if (e.region !== m_out_region || e.index !== m_bin_index ||
                    e.value !== m_bin_value || e.last !== m_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp r%0d i%0d v%0d l%0d, got r%0d i%0d v%0d l%0d",
                                 e.region, e.index, e.value, e.last, m_out_region,
                                 m_bin_index, m_bin_value, m_last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("watchdog: no progress in %0d cycles", WDOG_MAX);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_BINS_FIRST;
        cfg_wdata      = BINS_RESET;
        s_valid        = 1'b0;
        s_command      = CMD_ACCUM;
        s_region_id    = '0;
        s_chan_a       = '0;
        s_chan_b       = '0;
        s_chan_c       = '0;
        m_ready        = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        mismatches     = 0;
        words_checked  = 0;
        items_sent     = 0;
        readouts_sent  = 0;
        quiet_cycles   = 0;
        for (int k = 0; k < 3; k++) bins_reg[k] = BINS_RESET;
        for (int r = 0; r < NREG; r++) begin
            pixel_count[r] = 0;
            for (int s = 0; s < SLOTS; s++) bin_count[r][s] = 0;
        end
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        test_default_bins();
        test_bin_extremes();
        test_bins_changed();
        test_random_phase(0, 0, 36);
        test_random_phase(67, 0, 36);
        test_random_phase(0, 67, 36);
        test_random_phase(16, 16, 36);
        test_backpressure();
        wait_idle();

        $display("covered %0d words in, %0d readouts, %0d bins checked", items_sent,
                 readouts_sent, words_checked);
        $display("bin counts 0..31, gaps and stalls, long hold-off; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_bins.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
